>>> rtl/sps_pkg.sv
// Package for the sine polynomial unit: fixed-point types, constants and helpers.
// Holds the 2/pi scale factor, the order-19 coefficient set and the cell sideband type.
// Used by every module in the rtl folder; depends on nothing.
package sps_pkg;

	typedef logic signed [63:0] q56_t;
	typedef logic [63:0] u64_t;
	typedef logic [57:0] mag_t;
	typedef logic [28:0] half_t;
	typedef logic [57:0] pp_t;
	typedef logic [58:0] mid_t;
	typedef logic [88:0] lo_t;

	localparam int HALF = 29;
	localparam int NCOEF = 10;
	localparam int NCELL = NCOEF + 1;

	localparam u64_t TWO_OVER_PI = 64'hA2F9836E4E44152A;
	localparam u64_t Q56_ONE = 64'h0100_0000_0000_0000;
	localparam u64_t Q56_TWO = 64'h0200_0000_0000_0000;
	localparam lo_t LO_ROUND = lo_t'(1) << 55;
	localparam logic [58:0] OUT_ROUND = 59'(1) << 25;
	localparam logic [32:0] OUT_LIMIT = 33'(1) << 30;

	localparam q56_t COEF [NCOEF] = '{
		-64'sd3060,
		64'sd436963,
		-64'sd48192120,
		64'sd4101642667,
		-64'sd259323984760,
		64'sd11561005760345,
		-64'sd337355938868180,
		64'sd5742458909862625,
		-64'sd46546618701181590,
		64'sh01921FB54442D184
	};

	typedef struct packed {
		q56_t chi;
		q56_t chi2;
		logic neg;
		logic odd;
	} side_t;

	function automatic u64_t mag64(input q56_t v);
		u64_t r;
		r = v[63] ? u64_t'(-v) : u64_t'(v);
		return r;
	endfunction

endpackage

>>> rtl/sine_polynomial_unit_top.sv
// Pipeline: 3 reduction stages, 11 multiply cells of 6 stages each, 2 output
// stages. Throughput: one request per cycle while the output is not stalled;
// every stage stalls on its own, so bubbles are squeezed out and input is
// taken while a finished result waits at the output.
// Reset: arst_n clears all stage valid bits; the unit holds no other state.
module sine_polynomial_unit_top import sps_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] angle
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata   // [31:0] sine_value
);

	logic  front_valid, back_ready;
	side_t front_side;
	logic  c_valid [NCELL];
	logic  c_ready [NCELL];
	logic  c_in_valid [NCELL];
	logic  c_out_ready [NCELL];
	q56_t  c_x [NCELL];
	q56_t  c_y [NCELL];
	q56_t  c_add [NCELL];
	q56_t  c_res [NCELL];
	side_t c_side_in [NCELL];
	side_t c_side [NCELL];
	side_t side1;

	sps_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (s_axis_tvalid),
		.src_ready (s_axis_tready),
		.angle     (s_axis_tdata),
		.dst_valid (front_valid),
		.dst_ready (c_ready[0]),
		.side      (front_side)
	);

	always_comb begin
		side1 = c_side[0];
		side1.chi2 = c_res[0];
	end

	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		if (k == 0) begin : g_sq
			assign c_x[k] = front_side.chi;
			assign c_y[k] = front_side.chi;
			assign c_add[k] = '0;
			assign c_side_in[k] = front_side;
			assign c_in_valid[k] = front_valid;
		end else if (k == 1) begin : g_first
			assign c_x[k] = COEF[0];
			assign c_y[k] = c_res[k-1];
			assign c_add[k] = COEF[k];
			assign c_side_in[k] = side1;
			assign c_in_valid[k] = c_valid[k-1];
		end else if (k < NCOEF) begin : g_horner
			assign c_x[k] = c_res[k-1];
			assign c_y[k] = c_side[k-1].chi2;
			assign c_add[k] = COEF[k];
			assign c_side_in[k] = c_side[k-1];
			assign c_in_valid[k] = c_valid[k-1];
		end else begin : g_odd
			assign c_x[k] = c_res[k-1];
			assign c_y[k] = c_side[k-1].chi;
			assign c_add[k] = '0;
			assign c_side_in[k] = c_side[k-1];
			assign c_in_valid[k] = c_valid[k-1];
		end

		if (k == NCELL - 1) begin : g_last
			assign c_out_ready[k] = back_ready;
		end else begin : g_mid
			assign c_out_ready[k] = c_ready[k+1];
		end

		sps_mul_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.src_valid (c_in_valid[k]),
			.src_ready (c_ready[k]),
			.x         (c_x[k]),
			.y         (c_y[k]),
			.addend    (c_add[k]),
			.side_in   (c_side_in[k]),
			.dst_valid (c_valid[k]),
			.dst_ready (c_out_ready[k]),
			.res       (c_res[k]),
			.side_out  (c_side[k])
		);
	end

	sps_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.src_valid  (c_valid[NCELL-1]),
		.src_ready  (back_ready),
		.sum        (c_res[NCELL-1]),
		.side       (c_side[NCELL-1]),
		.dst_valid  (m_axis_tvalid),
		.dst_ready  (m_axis_tready),
		.sine_value (m_axis_tdata)
	);

endmodule

>>> rtl/sps_front.sv
// Range reduction for the sine polynomial unit: |angle| * 2/pi, nearest even multiple removed.
// Three pipeline stages producing chi, the quadrant parity and the sign flag.
// Depends on sps_pkg.
module sps_front import sps_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        src_valid,
	output logic        src_ready,
	input  logic [31:0] angle,
	output logic        dst_valid,
	input  logic        dst_ready,
	output side_t       side
);

	logic        v_s1, v_s2, v_s3;
	logic        en1, en2, en3;
	logic [31:0] mag32;
	u64_t        pl_s1, ph_s1, chia_s2;
	logic        neg_s1, neg_s2, neg_s3, odd_s3;
	q56_t        chi_s3;
	logic [56:0] rem;
	logic        gt;

	assign en3 = !v_s3 || dst_ready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign src_ready = en1;

	assign mag32 = angle[31] ? 32'(-angle) : angle;
	assign rem = chia_s2[56:0];
	assign gt = u64_t'(rem) > Q56_ONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= src_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			pl_s1 <= u64_t'(mag32) * u64_t'(TWO_OVER_PI[31:0]);
			ph_s1 <= u64_t'(mag32) * u64_t'(TWO_OVER_PI[63:32]);
			neg_s1 <= angle[31];
		end
		if (en2) begin
			chia_s2 <= ph_s1 + u64_t'(pl_s1[63:32]) + u64_t'(pl_s1[31]);
			neg_s2 <= neg_s1;
		end
		if (en3) begin
			chi_s3 <= q56_t'(u64_t'(rem) - (gt ? Q56_TWO : u64_t'(0)));
			odd_s3 <= chia_s2[57] ^ gt;
			neg_s3 <= neg_s2;
		end
	end

	assign dst_valid = v_s3;
	assign side.chi = chi_s3;
	assign side.chi2 = '0;
	assign side.neg = neg_s3;
	assign side.odd = odd_s3;

`ifndef SYNTHESIS
	a_chi_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (mag64(chi_s3) <= Q56_ONE))
		else $error("chi left the range [-1, 1]");
`endif

endmodule

>>> rtl/sps_mul_cell.sv
// One cell of the polynomial chain: res = round(x * y) + addend in signed Q7.56.
// Six stages: magnitudes, four 29x29 partial products, two partial sums, round, signed add.
// Depends on sps_pkg; the sideband travels unchanged beside the arithmetic.
module sps_mul_cell import sps_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  src_valid,
	output logic  src_ready,
	input  q56_t  x,
	input  q56_t  y,
	input  q56_t  addend,
	input  side_t side_in,
	output logic  dst_valid,
	input  logic  dst_ready,
	output q56_t  res,
	output side_t side_out
);

	logic  v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic  en1, en2, en3, en4, en5, en6;
	logic  neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	q56_t  add_s1, add_s2, add_s3, add_s4, add_s5;
	side_t side_s1, side_s2, side_s3, side_s4, side_s5, side_s6;
	mag_t  am_s1, bm_s1;
	pp_t   p0_s2, p1_s2, p2_s2, p3_s2, p0_s3, p3_s3, p3_s4;
	mid_t  mid_s3;
	lo_t   lo_s4;
	u64_t  mag_s5;
	q56_t  res_s6;

	assign en6 = !v_s6 || dst_ready;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign src_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= src_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			am_s1 <= mag_t'(mag64(x));
			bm_s1 <= mag_t'(mag64(y));
			neg_s1 <= x[63] ^ y[63];
			add_s1 <= addend;
			side_s1 <= side_in;
		end
		if (en2) begin
			p0_s2 <= pp_t'(am_s1[HALF-1:0]) * pp_t'(bm_s1[HALF-1:0]);
			p1_s2 <= pp_t'(am_s1[HALF-1:0]) * pp_t'(bm_s1[2*HALF-1:HALF]);
			p2_s2 <= pp_t'(am_s1[2*HALF-1:HALF]) * pp_t'(bm_s1[HALF-1:0]);
			p3_s2 <= pp_t'(am_s1[2*HALF-1:HALF]) * pp_t'(bm_s1[2*HALF-1:HALF]);
			neg_s2 <= neg_s1;
			add_s2 <= add_s1;
			side_s2 <= side_s1;
		end
		if (en3) begin
			mid_s3 <= mid_t'(p1_s2) + mid_t'(p2_s2);
			p0_s3 <= p0_s2;
			p3_s3 <= p3_s2;
			neg_s3 <= neg_s2;
			add_s3 <= add_s2;
			side_s3 <= side_s2;
		end
		if (en4) begin
			lo_s4 <= lo_t'(p0_s3) + (lo_t'(mid_s3) << HALF) + LO_ROUND;
			p3_s4 <= p3_s3;
			neg_s4 <= neg_s3;
			add_s4 <= add_s3;
			side_s4 <= side_s3;
		end
		if (en5) begin
			mag_s5 <= (u64_t'(p3_s4) << 2) + u64_t'(lo_s4[88:56]);
			neg_s5 <= neg_s4;
			add_s5 <= add_s4;
			side_s5 <= side_s4;
		end
		if (en6) begin
			res_s6 <= neg_s5 ? add_s5 - $signed(mag_s5) : add_s5 + $signed(mag_s5);
			side_s6 <= side_s5;
		end
	end

	assign dst_valid = v_s6;
	assign res = res_s6;
	assign side_out = side_s6;

`ifndef SYNTHESIS
	a_full_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!src_ready |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6))
		else $error("cell refused a request while a stage was empty");
	a_operand_width: assert property (@(posedge clk) disable iff (!arst_n)
		(src_valid && src_ready) |-> ((mag64(x) >> 58) == 0 && (mag64(y) >> 58) == 0))
		else $error("operand magnitude exceeds the multiplier width");
	a_last_stage_fed: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(v_s6) |-> $past(v_s5))
		else $error("last stage became valid without a request behind it");
`endif

endmodule

>>> rtl/sps_back.sv
// Output stage of the sine polynomial unit: sign decision, rounding to Q1.30, saturation.
// Two stages; the second is the output register of the stream.
// Depends on sps_pkg.
module sps_back import sps_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        src_valid,
	output logic        src_ready,
	input  q56_t        sum,
	input  side_t       side,
	output logic        dst_valid,
	input  logic        dst_ready,
	output logic [31:0] sine_value
);

	logic        v_s1, v_s2;
	logic        en1, en2;
	mag_t        m_s1;
	logic        neg_s1;
	logic [31:0] data_s2;
	logic [58:0] rsum;
	logic [32:0] rq, sq;

	assign en2 = !v_s2 || dst_ready;
	assign en1 = !v_s1 || en2;
	assign src_ready = en1;

	assign rsum = 59'(m_s1) + OUT_ROUND;
	assign rq = rsum[58:26];
	assign sq = (rq > OUT_LIMIT) ? OUT_LIMIT : rq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1) v_s1 <= src_valid;
			if (en2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			m_s1 <= mag_t'(mag64(sum));
			neg_s1 <= sum[63] != (side.odd != side.neg);
		end
		if (en2) begin
			data_s2 <= neg_s1 ? 32'(-sq) : sq[31:0];
		end
	end

	assign dst_valid = v_s2;
	assign sine_value = data_s2;

`ifndef SYNTHESIS
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> ($signed(data_s2) <= 32'sd1073741824 && $signed(data_s2) >= -32'sd1073741824))
		else $error("sine value outside [-1, 1]");
`endif

endmodule

>>> test/tb_sine_polynomial_unit_top.sv
// Testbench for sine_polynomial_unit_top: streams Q7.24 angles and checks each Q1.30 sine.
// A scoreboard class predicts every result in 128-bit fixed point and compares in order.
// Depends only on the RTL under rtl/, reached through sine_polynomial_unit_top.
`timescale 1ns / 1ps

module tb_sine_polynomial_unit_top;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int TAIL_CYCLES = 80;
	localparam int RANDOM_ANGLES = 400;
	localparam int HOLD_AFTER = 120;
	localparam int HOLD_CYCLES = 400;
	localparam logic [31:0] HALF_PI_Q24 = 32'd26353589;

	localparam logic [63:0] TWO_OVER_PI_Q64 = 64'hA2F9836E4E44152A;
	localparam logic [63:0] Q56_UNIT = 64'h0100_0000_0000_0000;
	localparam logic signed [63:0] SINE_COEF [10] = '{
		-64'sd3060,
		64'sd436963,
		-64'sd48192120,
		64'sd4101642667,
		-64'sd259323984760,
		64'sd11561005760345,
		-64'sd337355938868180,
		64'sd5742458909862625,
		-64'sd46546618701181590,
		64'sh01921FB54442D184
	};

	class sine_scoreboard;
		logic [31:0] pending_sines[$];
		int mismatches = 0;

		function logic [63:0] round_shift_mul(input logic [63:0] a, input logic [63:0] b,
				input int sh);
			logic [127:0] p;
			p = {64'b0, a} * {64'b0, b};
			p = (p + (128'd1 << (sh - 1))) >> sh;
			return p[63:0];
		endfunction

		// Product of two Q7.56 values, rounded on the magnitude.
		function logic signed [63:0] q56_mul(input logic signed [63:0] a,
				input logic signed [63:0] b);
			logic neg;
			logic [63:0] ma, mb, m;
			neg = a[63] ^ b[63];
			ma = a[63] ? -a : a;
			mb = b[63] ? -b : b;
			m = round_shift_mul(ma, mb, 56);
			m[63] = 1'b0;
			return neg ? -m : m;
		endfunction

		function logic [31:0] predict_sine(input logic [31:0] angle);
			logic is_neg, reflect, neg_out;
			logic [31:0] neg_angle;
			logic [63:0] mag, chi_a, npi2, rem, npi, sum_mag, q;
			logic signed [63:0] chi, chi2, acc, sum;
			is_neg = angle[31];
			neg_angle = -angle;
			mag = is_neg ? {32'b0, neg_angle} : {32'b0, angle};
			chi_a = round_shift_mul(mag, TWO_OVER_PI_Q64, 32);
			npi2 = chi_a >> 57;
			rem = chi_a - (npi2 << 57);
			// A remainder of exactly one stays at chi = +1.
			if (rem > Q56_UNIT) begin
				npi = npi2 + 64'd1;
				chi = rem - (Q56_UNIT << 1);
			end else begin
				npi = npi2;
				chi = rem;
			end
			chi2 = q56_mul(chi, chi);
			acc = SINE_COEF[0];
			for (int i = 1; i < 10; i++)
				acc = q56_mul(acc, chi2) + SINE_COEF[i];
			sum = q56_mul(acc, chi);
			reflect = (npi[0] == is_neg);
			neg_out = sum[63] != !reflect;
			sum_mag = sum[63] ? -sum : sum;
			q = (sum_mag + (64'd1 << 25)) >> 26;
			if (q > (64'd1 << 30))
				q = 64'd1 << 30;
			if (neg_out)
				q = -q;
			return q[31:0];
		endfunction

		function void note_angle(input logic [31:0] angle);
			pending_sines.push_back(predict_sine(angle));
		endfunction

		function void check_sine(input logic [31:0] sine);
			logic [31:0] want;
			if (pending_sines.size() == 0) begin
				$error("sine_value: result with no request pending, actual %0d", $signed(sine));
				mismatches++;
			end else begin
				want = pending_sines.pop_front();
				if (want !== sine) begin
					$error("sine_value mismatch: expected %0d, actual %0d",
						$signed(want), $signed(sine));
					mismatches++;
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;

	sine_scoreboard sine_sb = new();
	int angles_taken = 0;
	int idle_cycles = 0;
	int burst_left = 0;

	always #5 clk = ~clk;

	sine_polynomial_unit_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				sine_sb.note_angle(s_axis_tdata);
				angles_taken++;
			end
			if (m_axis_tvalid && m_axis_tready)
				sine_sb.check_sine(m_axis_tdata);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_sine_polynomial_unit_top: FAIL");
				$finish;
			end
		end
	end

	// The receiver changes its stall pattern now and then and holds off once for a long time.
	initial begin
		int mode, mode_left, phase;
		bit held;
		mode = 0;
		mode_left = 0;
		phase = 0;
		held = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && angles_taken >= HOLD_AFTER) begin
				held = 1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			phase++;
			case (mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= ($urandom_range(0, 3) != 0);
				2: m_axis_tready <= ($urandom_range(0, 3) == 0);
				default: m_axis_tready <= (phase % 4 == 0);
			endcase
		end
	end

	task automatic offer_angle(input logic [31:0] angle);
		int gap;
		s_axis_tdata <= angle;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(0, 12);
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	function automatic logic [31:0] random_angle();
		logic [31:0] m;
		int unsigned k;
		case ($urandom_range(0, 3))
			0: m = $urandom();
			1: m = $urandom_range(0, 1 << 26);
			2: begin
				k = $urandom_range(0, 80);
				m = k * HALF_PI_Q24 + k / 4 + $urandom_range(0, 128) - 64;
			end
			default: m = $urandom_range(0, 32'h7FFF_FFFF);
		endcase
		return $urandom_range(0, 1) ? -m : m;
	endfunction

	initial begin
		logic [31:0] directed_angles[$];
		directed_angles = '{
			32'd0, 32'd1, 32'hFFFF_FFFF, 32'd2, 32'h7FFF_FFFF, 32'h8000_0000,
			32'd16777216, -32'd16777216,
			HALF_PI_Q24, HALF_PI_Q24 + 32'd1, HALF_PI_Q24 - 32'd1, HALF_PI_Q24 + 32'd2,
			-HALF_PI_Q24, -(HALF_PI_Q24 + 32'd1),
			32'd52707179, -32'd52707179, 32'd79060768, -32'd79060768, 32'd105414357,
			32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF, 32'hFFFF_0000
		};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_angles[i])
			offer_angle(directed_angles[i]);
		for (int i = 0; i < RANDOM_ANGLES; i++)
			offer_angle(random_angle());
		s_axis_tvalid <= 1'b0;
		while (sine_sb.pending_sines.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sine_sb.mismatches == 0)
			$display("tb_sine_polynomial_unit_top: PASS");
		else
			$display("tb_sine_polynomial_unit_top: FAIL");
		$finish;
	end

endmodule

>>> filelist.f
rtl/sps_pkg.sv
rtl/sps_front.sv
rtl/sps_mul_cell.sv
rtl/sps_back.sv
rtl/sine_polynomial_unit_top.sv
test/tb_sine_polynomial_unit_top.sv
